// ===== hw/rtl/rls_pkg.sv =====
// Shared types, constants and saturation helpers for the RLS estimator.
package rls_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;
  localparam int ACC_W      = 56;   // exact sum of rounded Q16.16 products
  localparam int DEN_W      = 56;   // divider denominator width
  localparam int NUM_W      = 48;   // divider numerator: Q16.16 value shifted by 16

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FORGET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ICOV   = 1'b1;

  localparam logic [16:0] LAM_MIN    = 17'd32768;
  localparam logic [16:0] LAM_MAX    = 17'd65536;
  localparam logic [16:0] LAM_RESET  = 17'd65536;
  localparam logic [30:0] ICOV_RESET = 31'd65536000;
  localparam logic signed [31:0] Q_ONE   = 32'sd65536;
  localparam logic signed [31:0] Q_MAX   = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN   = 32'sh80000000;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_TERM = 5'b00010,
    S_FIN  = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  typedef enum logic [6:0] {
    P_ERR  = 7'b0000001,
    P_G    = 7'b0000010,
    P_RHO  = 7'b0000100,
    P_K    = 7'b0001000,
    P_AROW = 7'b0010000,
    P_PN   = 7'b0100000,
    P_TH   = 7'b1000000
  } pass_t;

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh000000007fffffff) r = Q_MAX;
    else if (x < -64'sh0000000080000000) r = Q_MIN;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic ovf32(input logic signed [63:0] x);
    return (x > 64'sh000000007fffffff) || (x < -64'sh0000000080000000);
  endfunction

endpackage

// ===== hw/rtl/rls_if.sv =====
// Valid/ready channel interfaces for RLS input items and results.
interface rls_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [31:0] regressor;
  logic signed [31:0] measured_output;
  logic               last_element;

  modport source(output valid, req_type, regressor, measured_output, last_element,
                 input ready);
  modport sink(input valid, req_type, regressor, measured_output, last_element,
               output ready);
endinterface

interface rls_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] prediction_error;
  logic signed [31:0] coefficient;
  logic [3:0]         coefficient_index;
  logic               last_result;
  logic               saturated;

  modport source(output valid, prediction_error, coefficient, coefficient_index,
                 last_result, saturated, input ready);
  modport sink(input valid, prediction_error, coefficient, coefficient_index,
               last_result, saturated, output ready);
endinterface

// ===== hw/rtl/rls_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/rls_mac.sv =====
// Shared Q16.16 multiply, round-to-nearest and accumulate unit (3 stages).
module rls_mac import rls_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    go,
  input  logic                    clr,
  input  logic signed [31:0]      a,
  input  logic signed [31:0]      b,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [63:0]      prod_r;
  logic signed [48:0]      rnd_r;
  logic signed [ACC_W-1:0] acc_r;
  logic                    v1_r, v2_r, c1_r, c2_r;
  logic [63:0]             mag;
  logic [47:0]             rmag;

  // control pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      c1_r <= 1'b0;
      c2_r <= 1'b0;
    end else begin
      v1_r <= go;
      v2_r <= v1_r;
      c1_r <= clr;
      c2_r <= c1_r;
    end
  end

  // rounding: ties away from zero on the magnitude
  always_comb begin
    mag  = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
    rmag = 48'((mag + 64'd32768) >> 16);
  end

  always_ff @(posedge clk) begin
    if (go) begin
      prod_r <= 64'(a) * 64'(b);
    end
    if (v1_r) begin
      rnd_r <= prod_r[63] ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
    end
    if (v2_r) begin
      acc_r <= (c2_r ? '0 : acc_r) + ACC_W'(rnd_r);
    end
  end

  assign acc = acc_r;

endmodule

// ===== hw/rtl/rls_div.sv =====
// Iterative restoring divider: rounded signed quotient, saturated to Q16.16.
module rls_div import rls_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    busy,
  output logic                    done,
  output logic signed [31:0]      quo,
  output logic                    ovf
);

  localparam int DVD_W = DEN_W + 1;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r;
  logic [DEN_W-1:0] rem_r, den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r, neg_r;
  logic [NUM_W-1:0] nmag;
  logic [DVD_W-1:0] trial, diff;
  logic             fits;

  always_comb begin
    nmag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    trial = {rem_r, dvd_r[DVD_W-1]};
    diff  = trial - {1'b0, den_r};
    fits  = trial >= {1'b0, den_r};
  end

  // sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle; adding den/2 first gives round to nearest
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      dvd_r <= DVD_W'(nmag) + DVD_W'(den >> 1);
      rem_r <= '0;
      den_r <= den;
      neg_r <= num[NUM_W-1];
    end else if (busy_r) begin
      rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      dvd_r <= {dvd_r[DVD_W-2:0], fits};
    end
  end

  always_comb begin
    ovf = neg_r ? (dvd_r > DVD_W'(64'h80000000)) : (dvd_r > DVD_W'(64'h7fffffff));
    if (neg_r) quo = ovf ? Q_MIN : -$signed(dvd_r[31:0]);
    else       quo = ovf ? Q_MAX : $signed(dvd_r[31:0]);
  end

  assign busy = busy_r;
  assign done = done_r;

endmodule

// ===== hw/rtl/recursive_least_squares_estimator_core.sv =====
// RLS estimator top: element buffer, update sequencer, covariance RAM.
//
//  channel | dir | handshake        | payload
//  in_if   | in  | valid/ready      | req_type, regressor, measured_output, last_element
//  out_if  | out | valid/ready      | prediction_error, coefficient, coefficient_index,
//          |     |                  | last_result, saturated
//  cfg     | in  | cfg_we           | cfg_index, cfg_data
//
// Element and restart items are taken back to back while idle. An update uses the
// shared multiply-accumulate unit plus (N^2 + N) divisions in the shared divider,
// then N results. No clearing pass: after reset or restart the covariance reads as
// its diagonal value until the first update writes the RAM. Input is not ready from
// the last element until the final result transaction; results hold under
// out_if.ready low.
module recursive_least_squares_estimator_core import rls_pkg::*; #(
  parameter int NUM_PARAMS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rls_in_if.sink                in_if,
  rls_out_if.source             out_if
);

  localparam int IW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
  localparam int CW = $clog2(NUM_PARAMS + 1);
  localparam int NN = NUM_PARAMS * NUM_PARAMS;
  localparam int MD = 2 * NN;
  localparam int AW = $clog2(MD);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_PARAMS - 1);

  state_t             st_r;
  pass_t              pass_r;
  logic [1:0]         ph_r;
  logic [IW-1:0]      o_r, t_r, i_r;
  logic [CW-1:0]      cnt_r;
  logic signed [31:0] h_r [NUM_PARAMS];
  logic signed [31:0] th_r [NUM_PARAMS];
  logic signed [31:0] g_r [NUM_PARAMS];
  logic signed [31:0] k_r [NUM_PARAMS];
  logic signed [31:0] arow_r [NUM_PARAMS];
  logic signed [31:0] err_r, y_r;
  logic [DEN_W-1:0]   rho_r;
  logic               sat_r, fresh_r, bank_r, out_v_r;
  logic [30:0]        diag_r, icov_r;
  logic [16:0]        ff_r, lam;

  logic                    in_acc, out_acc;
  logic                    mac_go, term_last, o_last;
  logic signed [31:0]      op_a, op_b, p_rd, acc_sat;
  logic signed [ACC_W-1:0] mac_acc;
  logic [IW-1:0]           prow, pcol;
  logic [AW-1:0]           raddr, waddr;
  logic [31:0]             ram_rdata;
  logic                    ram_we;
  logic                    div_start, div_busy, div_done, div_ovf;
  logic signed [31:0]      div_quo;
  logic signed [NUM_W-1:0] div_num;
  logic [DEN_W-1:0]        div_den;
  logic signed [63:0]      acc64, fin_val;
  logic signed [ACC_W:0]   rho_sum;
  pass_t                   adv_pass;
  state_t                  adv_st;

  assign in_acc  = in_if.valid && in_if.ready;
  assign out_acc = out_if.valid && out_if.ready;

  // lambda clamped to 0.5..1.0
  always_comb begin
    if (ff_r < LAM_MIN)      lam = LAM_MIN;
    else if (ff_r > LAM_MAX) lam = LAM_MAX;
    else                     lam = ff_r;
  end

  // covariance addressing: G walks a row, PN walks a column
  always_comb begin
    prow  = (pass_r == P_PN) ? t_r : o_r;
    pcol  = (pass_r == P_PN) ? o_r : t_r;
    raddr = AW'(int'(bank_r) * NN + int'(prow) * NUM_PARAMS + int'(pcol));
    waddr = AW'(int'(!bank_r) * NN + int'(i_r) * NUM_PARAMS + int'(o_r));
    if (fresh_r) p_rd = (prow == pcol) ? $signed({1'b0, diag_r}) : '0;
    else         p_rd = $signed(ram_rdata);
  end

  // operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (pass_r)
      P_ERR:  begin op_a = h_r[t_r];    op_b = th_r[t_r]; end
      P_G:    begin op_a = p_rd;        op_b = h_r[t_r];  end
      P_RHO:  begin op_a = h_r[t_r];    op_b = g_r[t_r];  end
      P_AROW: begin op_a = k_r[i_r];    op_b = h_r[o_r];  end
      P_PN:   begin op_a = arow_r[t_r]; op_b = p_rd;      end
      P_TH:   begin op_a = err_r;       op_b = k_r[o_r];  end
      default: begin op_a = '0;         op_b = '0;        end
    endcase
  end

  assign mac_go    = (st_r == S_TERM) && (ph_r == 2'd1);
  assign term_last = (pass_r == P_AROW) || (pass_r == P_TH) || (t_r == LAST_IDX);
  assign o_last    = (pass_r == P_ERR) || (pass_r == P_RHO) || (o_r == LAST_IDX);

  // finishing values from the accumulator
  always_comb begin
    acc64   = 64'(mac_acc);
    acc_sat = sat32(acc64);
    rho_sum = (ACC_W + 1)'(mac_acc) + (ACC_W + 1)'(lam);
    fin_val = '0;
    case (pass_r)
      P_ERR:  fin_val = 64'(y_r) - acc64;
      P_G:    fin_val = acc64;
      P_AROW: fin_val = ((o_r == i_r) ? 64'(Q_ONE) : 64'sd0) - acc64;
      P_PN:   fin_val = acc64;
      P_TH:   fin_val = 64'(th_r[o_r]) + acc64;
      default: fin_val = acc64;
    endcase
  end

  // next pass once the outer index is exhausted
  always_comb begin
    adv_pass = pass_r;
    adv_st   = S_TERM;
    case (pass_r)
      P_ERR:  adv_pass = P_G;
      P_G:    adv_pass = P_RHO;
      P_RHO:  begin adv_pass = P_K; adv_st = S_FIN; end
      P_K:    adv_pass = P_AROW;
      P_AROW: adv_pass = P_PN;
      P_PN:   adv_pass = (i_r == LAST_IDX) ? P_TH : P_AROW;
      P_TH:   adv_st = S_OUT;
      default: adv_pass = P_ERR;
    endcase
  end

  assign div_start = (st_r == S_FIN) && ((pass_r == P_K) || (pass_r == P_PN));
  assign div_num   = (pass_r == P_K) ? $signed({g_r[o_r], 16'h0000})
                                     : $signed({acc_sat, 16'h0000});
  assign div_den   = (pass_r == P_K) ? rho_r : DEN_W'(lam);
  assign ram_we    = (st_r == S_DIV) && div_done && (pass_r == P_PN);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_r   <= LAM_RESET;
      icov_r <= ICOV_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FORGET: ff_r   <= cfg_data[16:0];
        REG_ICOV:   icov_r <= cfg_data;
        default:    ff_r   <= ff_r;
      endcase
    end
  end

  // update sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      pass_r  <= P_ERR;
      ph_r    <= '0;
      o_r     <= '0;
      t_r     <= '0;
      i_r     <= '0;
      cnt_r   <= '0;
      sat_r   <= 1'b0;
      fresh_r <= 1'b1;
      bank_r  <= 1'b0;
      out_v_r <= 1'b0;
      diag_r  <= ICOV_RESET;
      for (int n = 0; n < NUM_PARAMS; n++) begin
        h_r[n]  <= '0;
        th_r[n] <= '0;
      end
    end else begin
      case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_if.req_type) begin
              // restart: covariance back to its diagonal, estimates cleared
              fresh_r <= 1'b1;
              diag_r  <= icov_r;
              cnt_r   <= '0;
              for (int n = 0; n < NUM_PARAMS; n++) begin
                h_r[n]  <= '0;
                th_r[n] <= '0;
              end
            end else begin
              if (cnt_r < CW'(NUM_PARAMS)) begin
                h_r[cnt_r[IW-1:0]] <= in_if.regressor;
                cnt_r              <= cnt_r + 1'b1;
              end
              if (in_if.last_element) begin
                y_r    <= in_if.measured_output;
                sat_r  <= 1'b0;
                st_r   <= S_TERM;
                pass_r <= P_ERR;
                ph_r   <= '0;
                o_r    <= '0;
                t_r    <= '0;
                i_r    <= '0;
              end
            end
          end
        end
        S_TERM: begin
          ph_r <= ph_r + 1'b1;
          if (ph_r == 2'd3) begin
            if (term_last) st_r <= S_FIN;
            else           t_r  <= t_r + 1'b1;
          end
        end
        S_FIN: begin
          t_r <= '0;
          case (pass_r)
            P_ERR:  begin err_r <= sat32(fin_val); sat_r <= sat_r | ovf32(fin_val); end
            P_G:    begin g_r[o_r] <= sat32(fin_val); sat_r <= sat_r | ovf32(fin_val); end
            P_RHO: begin
              if (rho_sum < 1) begin
                rho_r <= DEN_W'(1);
                sat_r <= 1'b1;
              end else begin
                rho_r <= rho_sum[DEN_W-1:0];
              end
            end
            P_AROW: begin arow_r[o_r] <= sat32(fin_val); sat_r <= sat_r | ovf32(fin_val); end
            P_PN:   sat_r <= sat_r | ovf32(fin_val);
            P_TH:   begin th_r[o_r] <= sat32(fin_val); sat_r <= sat_r | ovf32(fin_val); end
            default: sat_r <= sat_r;
          endcase
          if ((pass_r == P_K) || (pass_r == P_PN)) begin
            st_r <= S_DIV;
          end else if (!o_last) begin
            o_r  <= o_r + 1'b1;
            st_r <= S_TERM;
          end else begin
            o_r    <= '0;
            pass_r <= adv_pass;
            st_r   <= adv_st;
            if (adv_st == S_OUT) begin
              out_v_r <= 1'b1;
              cnt_r   <= '0;
              for (int n = 0; n < NUM_PARAMS; n++) h_r[n] <= '0;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            sat_r <= sat_r | div_ovf;
            if (pass_r == P_K) k_r[o_r] <= div_quo;
            if (!o_last) begin
              o_r  <= o_r + 1'b1;
              st_r <= (pass_r == P_K) ? S_FIN : S_TERM;
            end else begin
              o_r    <= '0;
              pass_r <= adv_pass;
              st_r   <= adv_st;
              if (pass_r == P_PN) begin
                if (i_r == LAST_IDX) begin
                  bank_r  <= !bank_r;
                  fresh_r <= 1'b0;
                end else begin
                  i_r <= i_r + 1'b1;
                end
              end
            end
          end
        end
        S_OUT: begin
          if (out_acc) begin
            if (o_r == LAST_IDX) begin
              out_v_r <= 1'b0;
              o_r     <= '0;
              st_r    <= S_IDLE;
            end else begin
              o_r <= o_r + 1'b1;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  rls_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mac_go),
    .clr   (t_r == '0),
    .a     (op_a),
    .b     (op_b),
    .acc   (mac_acc)
  );

  rls_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo),
    .ovf   (div_ovf)
  );

  // covariance, two banks: old P read while new P is written
  rls_ram #(.WIDTH(32), .DEPTH(MD)) u_pram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (div_quo),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  assign in_if.ready              = (st_r == S_IDLE);
  assign out_if.valid             = out_v_r;
  assign out_if.prediction_error  = err_r;
  assign out_if.coefficient       = th_r[o_r];
  assign out_if.coefficient_index = 4'(o_r);
  assign out_if.last_result       = (o_r == LAST_IDX);
  assign out_if.saturated         = sat_r;

`ifndef SYNTH
  // results are only presented while the sequencer is in its output phase
  a_out_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (st_r == S_OUT)) else $error("result valid outside output phase");

  // the divider is never restarted while it works
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy) else $error("divider started while busy");

  // a last element closes the input until the update has been delivered
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_if.req_type && in_if.last_element) |=> !in_if.ready)
    else $error("input ready right after last element");

  // the final result transaction returns the block to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_if.last_result) |=> (st_r == S_IDLE))
    else $error("not idle after final result");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the RLS estimator core: Q16.16 update predictor, scoreboard and stimulus.
module tb_top;
  import rls_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NP         = 4;
  localparam int IDLE_LIMIT = 40000;   // cycles with no transaction before giving up
  localparam int DRAIN_WAIT = 2500;    // covers one full update with divisions

  typedef struct {
    logic signed [31:0] err;
    logic signed [31:0] coef;
    logic [3:0]         idx;
    logic               last;
    logic               sat;
  } rls_result_t;

  // Scoreboard: predicts each update and checks result transactions in order
  class rls_scoreboard;
    logic [16:0]        lam_reg;
    logic [30:0]        icov_reg;
    logic signed [31:0] covar[NP*NP];
    logic signed [31:0] theta[NP];
    logic signed [31:0] gain[NP];
    logic signed [31:0] hbuf[NP];
    int                 nfill;
    bit                 sat_flag;
    rls_result_t        pending[$];
    int                 errors;

    function new();
      lam_reg  = LAM_RESET;
      icov_reg = ICOV_RESET;
      errors   = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < NP*NP; i++) covar[i] = 0;
      for (int i = 0; i < NP; i++) begin
        covar[i*NP+i] = $signed({1'b0, icov_reg});
        theta[i] = 0;
        gain[i]  = 0;
        hbuf[i]  = 0;
      end
      nfill = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_FORGET) lam_reg = data[16:0];
      else icov_reg = data[30:0];
    endfunction

    function longint clamp32(longint x);
      if (x > 64'sd2147483647) begin
        sat_flag = 1;
        return 64'sd2147483647;
      end
      if (x < -64'sd2147483648) begin
        sat_flag = 1;
        return -64'sd2147483648;
      end
      return x;
    endfunction

    // round to nearest, ties away from zero; d > 0
    function longint div_round(longint n, longint d);
      longint unsigned mag;
      longint unsigned q;
      mag = (n < 0) ? longint'(-n) : n;
      q = (mag + longint'(d) / 2) / longint'(d);
      return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    function longint qmul(longint a, longint b);
      return div_round(a * b, 65536);
    endfunction

    // one full covariance/estimate update; returns the prediction error
    function longint update(longint y);
      longint lam, acc, rho, e, b;
      longint g[NP];
      longint am[NP*NP];
      logic signed [31:0] pn[NP*NP];
      lam = lam_reg;
      if (lam < 32768) lam = 32768;
      if (lam > 65536) lam = 65536;
      acc = 0;
      for (int i = 0; i < NP; i++) acc += qmul(hbuf[i], theta[i]);
      e = clamp32(y - acc);
      for (int i = 0; i < NP; i++) begin
        acc = 0;
        for (int j = 0; j < NP; j++) acc += qmul(covar[i*NP+j], hbuf[j]);
        g[i] = clamp32(acc);
      end
      acc = 0;
      for (int i = 0; i < NP; i++) acc += qmul(hbuf[i], g[i]);
      rho = acc + lam;
      if (rho < 1) begin
        rho = 1;
        sat_flag = 1;
      end
      for (int i = 0; i < NP; i++) gain[i] = 32'(clamp32(div_round(g[i] * 65536, rho)));
      for (int i = 0; i < NP; i++)
        for (int j = 0; j < NP; j++)
          am[i*NP+j] = clamp32(((i == j) ? 65536 : 0) - qmul(gain[i], hbuf[j]));
      for (int i = 0; i < NP; i++)
        for (int j = 0; j < NP; j++) begin
          acc = 0;
          for (int k = 0; k < NP; k++) acc += qmul(am[i*NP+k], covar[k*NP+j]);
          b = clamp32(acc);
          pn[i*NP+j] = 32'(clamp32(div_round(b * 65536, lam)));
        end
      covar = pn;
      for (int i = 0; i < NP; i++)
        theta[i] = 32'(clamp32(longint'(theta[i]) + qmul(e, gain[i])));
      return e;
    endfunction

    // accepted input transaction
    function void note_input(logic rt, logic signed [31:0] h, logic signed [31:0] y,
                             logic le);
      longint e;
      rls_result_t r;
      if (rt) begin
        restart();
        return;
      end
      if (nfill < NP) begin
        hbuf[nfill] = h;
        nfill++;
      end
      if (!le) return;
      sat_flag = 0;
      e = update(y);
      for (int i = 0; i < NP; i++) begin
        r.err  = 32'(e);
        r.coef = theta[i];
        r.idx  = 4'(i);
        r.last = (i == NP-1);
        r.sat  = sat_flag;
        pending.push_back(r);
      end
      for (int i = 0; i < NP; i++) hbuf[i] = 0;
      nfill = 0;
    endfunction

    // accepted result transaction
    function void check(rls_result_t act);
      rls_result_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result transaction, coefficient_index %0d", act.idx);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (act.err !== exp.err) begin
        $error("prediction_error: expected %0d, got %0d", exp.err, act.err);
        errors++;
      end
      if (act.coef !== exp.coef) begin
        $error("coefficient: expected %0d, got %0d", exp.coef, act.coef);
        errors++;
      end
      if (act.idx !== exp.idx) begin
        $error("coefficient_index: expected %0d, got %0d", exp.idx, act.idx);
        errors++;
      end
      if (act.last !== exp.last) begin
        $error("last_result: expected %0b, got %0b", exp.last, act.last);
        errors++;
      end
      if (act.sat !== exp.sat) begin
        $error("saturated: expected %0b, got %0b", exp.sat, act.sat);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_FORGET;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rls_in_if  in_if();
  rls_out_if out_if();

  recursive_least_squares_estimator_core #(.NUM_PARAMS(NP)) dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_if(in_if.sink), .out_if(out_if.source)
  );

  always #6 clk = ~clk;

  rls_scoreboard sb = new();
  bit  no_idle = 0;
  int  idle_cycles = 0;
  int  hold_left = 0;

  initial begin
    in_if.valid = 0;
    in_if.req_type = 0;
    in_if.regressor = 0;
    in_if.measured_output = 0;
    in_if.last_element = 0;
    out_if.ready = 0;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // result-side backpressure, mostly short stalls with an occasional long one
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (!rst_n || no_idle) begin
      hold_left = 0;
      out_if.ready <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (r < 60) begin
      out_if.ready <= 1'b1;
    end else if (r < 95) begin
      out_if.ready <= 1'b0;
    end else begin
      hold_left = $urandom_range(15, 60);
      out_if.ready <= 1'b0;
    end
  end

  // monitor both channels and count quiet cycles
  always @(posedge clk) begin
    rls_result_t act;
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        sb.note_input(in_if.req_type, in_if.regressor, in_if.measured_output,
                      in_if.last_element);
      if (out_if.valid && out_if.ready) begin
        act.err  = out_if.prediction_error;
        act.coef = out_if.coefficient;
        act.idx  = out_if.coefficient_index;
        act.last = out_if.last_result;
        act.sat  = out_if.saturated;
        sb.check(act);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // one input transaction, valid stays high across back-to-back items
  task automatic send(input logic rt, input logic signed [31:0] h,
                      input logic signed [31:0] y, input logic le);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid           <= 1'b1;
    in_if.req_type        <= rt;
    in_if.regressor       <= h;
    in_if.measured_output <= y;
    in_if.last_element    <= le;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // wait for every expected result, then let the block settle
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // mostly modest magnitudes, sometimes full range or extremes
  function automatic logic signed [31:0] rand_q();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $signed($urandom_range(0, 262143)) - 131072;
    if (r < 90) return $urandom;
    if (r < 95) return Q_MAX;
    return Q_MIN;
  endfunction

  // one sample: a vector of len elements, the last carrying y
  task automatic send_vector(input int len);
    for (int i = 0; i < len; i++)
      send(1'b0, rand_q(), rand_q(), i == len-1);
  endtask

  int sent;

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: defaults, extremes, short/long vectors, restart mid-vector
    send(1'b1, Q_MAX, Q_MIN, 1'b1);
    send(1'b0, Q_ONE, 0, 1'b0);
    send(1'b0, 0, 0, 1'b0);
    send(1'b0, 0, 0, 1'b0);
    send(1'b0, 0, 2 * Q_ONE, 1'b1);
    send(1'b0, Q_MAX, 0, 1'b0);
    send(1'b0, Q_MIN, 0, 1'b0);
    send(1'b0, Q_MAX, 0, 1'b0);
    send(1'b0, Q_MIN, Q_MAX, 1'b1);
    send(1'b0, -Q_ONE, Q_MIN, 1'b1);                 // short vector
    for (int i = 0; i < 6; i++)                      // long vector
      send(1'b0, (i + 1) * 16384, -Q_ONE, i == 5);
    send(1'b0, Q_ONE, 0, 1'b0);
    send(1'b0, Q_ONE, 0, 1'b0);
    send(1'b1, 0, 0, 1'b0);                          // drop partial vector
    send(1'b0, 0, 0, 1'b0);
    send(1'b0, 0, 0, 1'b0);
    send(1'b0, 0, 0, 1'b0);
    send(1'b0, 0, 32'sh00012345, 1'b1);              // all-zero regressor

    // phases with different register settings
    for (int p = 0; p < 6; p++) begin
      drain();
      no_idle = (p == 2);
      case (p)
        0: begin
          write_cfg(REG_FORGET, 31'd32768);
          write_cfg(REG_ICOV, 31'd1);
        end
        1: begin
          write_cfg(REG_FORGET, 31'd65536);
          write_cfg(REG_ICOV, 31'h7fffffff);
        end
        2: begin
          write_cfg(REG_FORGET, 31'd0);
          write_cfg(REG_ICOV, 31'd0);
        end
        3: begin
          write_cfg(REG_FORGET, 31'h7fffffff);
          write_cfg(REG_ICOV, CFG_DATA_W'($urandom));
        end
        default: begin
          write_cfg(REG_FORGET, CFG_DATA_W'($urandom_range(32768, 65536)));
          write_cfg(REG_ICOV, CFG_DATA_W'($urandom_range(1, 32'h7fffffff)));
        end
      endcase
      send(1'b1, $urandom, $urandom, 1'($urandom_range(0, 1)));
      sent = 0;
      while (sent < 32) begin
        int r;
        int len;
        r = $urandom_range(0, 99);
        len = (r < 85) ? NP : $urandom_range(1, 6);
        if (r >= 95) begin
          send(1'b1, $urandom, $urandom, 1'($urandom_range(0, 1)));
          sent++;
        end
        send_vector(len);
        sent += len;
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/rls_pkg.sv
hw/rtl/rls_if.sv
hw/rtl/rls_ram.sv
hw/rtl/rls_mac.sv
hw/rtl/rls_div.sv
hw/rtl/recursive_least_squares_estimator_core.sv
tb/tb_top.sv
